// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; compiled out under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Assert a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Assert that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ----- design/lobm_pkg.sv -----
// ---------------------------------------------------------------------------
// Order book matcher package
// Shared constants, payload types and codes.
// ---------------------------------------------------------------------------
`default_nettype none
package lobm_pkg;
   localparam int ORDER_SLOTS = 32;
   localparam int SLOT_W = (ORDER_SLOTS > 32) ? 6 : ((ORDER_SLOTS > 16) ? 5 :
                           ((ORDER_SLOTS > 8) ? 4 : ((ORDER_SLOTS > 4) ? 3 :
                           ((ORDER_SLOTS > 2) ? 2 : 1))));
   localparam int CNT_W = SLOT_W + 1;

   localparam logic OP_SUBMIT = 1'b0;
   localparam logic OP_CANCEL = 1'b1;
   localparam logic SIDE_BUY = 1'b0;
   localparam logic SIDE_SELL = 1'b1;
   localparam logic KIND_LIMIT = 1'b0;
   localparam logic KIND_MARKET = 1'b1;
   localparam logic RES_TRADE = 1'b0;
   localparam logic RES_SUMMARY = 1'b1;

   localparam logic [2:0] ST_ACCEPTED = 3'd0;
   localparam logic [2:0] ST_REJECTED = 3'd1;
   localparam logic [2:0] ST_CANCELLED = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_BOOK_FULL = 3'd4;

   typedef struct packed {
      logic        operation;
      logic        order_side;
      logic        order_kind;
      logic [31:0] order_id;
      logic [31:0] limit_price;
      logic [23:0] order_quantity;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] maker_id;
      logic [31:0] taker_id;
      logic [31:0] trade_price;
      logic [23:0] fill_quantity;
      logic [2:0]  status;
      logic [23:0] leftover_quantity;
      logic        bid_present;
      logic [31:0] best_bid_price;
      logic        ask_present;
      logic [31:0] best_ask_price;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic        side;
      logic [31:0] order_id;
      logic [31:0] price;
      logic [23:0] quantity;
      logic [31:0] arrival;
   } slot_type;
endpackage
`default_nettype wire

// ----- design/lobm_req_if.sv -----
// ---------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one order transaction.
// ---------------------------------------------------------------------------
`default_nettype none
interface lobm_req_if import lobm_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/lobm_rsp_if.sv -----
// ---------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one result transaction.
// ---------------------------------------------------------------------------
`default_nettype none
interface lobm_rsp_if import lobm_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/lobm_slot_ram.sv -----
// ---------------------------------------------------------------------------
// Slot store RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module lobm_slot_ram import lobm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [SLOT_W-1:0] wr_addr,
   input  wire slot_type          wr_data,
   input  wire logic [SLOT_W-1:0] rd_addr,
   output slot_type               rd_data
);
   slot_type mem [ORDER_SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- design/limit_order_book_matcher_unit.sv -----
// ---------------------------------------------------------------------------
// Limit order book matcher
// Price-time priority matching over a slot store held in a RAM.
// ---------------------------------------------------------------------------
// Resting orders live in a single-port-read RAM of ORDER_SLOTS entries with
// valid bits in flip-flops. A submit runs repeated scans of the store, one
// slot read per cycle, each scan finding the best opposing order (best price,
// then oldest); every fill emits one trade transaction and updates that slot.
// A free slot for a limit remainder comes from the valid bits directly. A
// final scan computes best bid and best ask for the summary transaction.
// A submit runs a scan and a fill for each trade, then the scan that finds no
// further cross (skipped when the last fill uses up the order), then the
// summary scan, and then hands the summary over. A cancel runs one scan for
// the order id and then the summary scan; a rejected zero-quantity order
// runs only the summary scan. A response side that holds off a pending
// trade or summary stalls the matcher. The next request is taken once the
// summary has been accepted on the response side.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module limit_order_book_matcher_unit import lobm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   lobm_req_if.sink   req,
   lobm_rsp_if.source rsp
);
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_DECIDE = 6'b000100,
      S_TRADE = 6'b001000,
      S_SUM   = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [ORDER_SLOTS-1:0] valid_ff, valid_in;
   logic [31:0] arrival_ff, arrival_in;
   logic [CNT_W-1:0] scan_ff, scan_in;      // slot whose read is issued next
   logic rd_pend_ff, rd_pend_in;            // read data valid next
   logic [SLOT_W-1:0] rd_idx_ff, rd_idx_in;
   // best candidate for the trade or cancel scan
   logic found_ff, found_in;
   logic [SLOT_W-1:0] best_idx_ff, best_idx_in;
   slot_type best_ff, best_in;
   // best bid/ask for summary scan
   logic bid_ff, bid_in, ask_ff, ask_in;
   logic [31:0] bidp_ff, bidp_in, askp_ff, askp_in;
   logic [31:0] bida_ff, bida_in, aska_ff, aska_in;
   logic [23:0] qty_ff, qty_in;
   logic [2:0] status_ff, status_in;
   logic [23:0] left_ff, left_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic wr_en;
   logic [SLOT_W-1:0] wr_addr, rd_addr;
   slot_type wr_data, rd_data;

   lobm_slot_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // first free slot from the valid bits
   logic free_any;
   logic [SLOT_W-1:0] free_idx;
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   logic [31:0] age_new, age_best;
   logic [23:0] fill;
   logic cand_ok, better, crosses;
   always_comb begin
      age_new = arrival_ff - rd_data.arrival;
      age_best = arrival_ff - best_ff.arrival;
      fill = (qty_ff < best_ff.quantity) ? qty_ff : best_ff.quantity;
      if (req_ff.order_side == SIDE_BUY) begin
         crosses = (req_ff.order_kind == KIND_MARKET) || (best_ff.price <= req_ff.limit_price);
      end else begin
         crosses = (req_ff.order_kind == KIND_MARKET) || (best_ff.price >= req_ff.limit_price);
      end
      if (req_ff.operation == OP_CANCEL) begin
         cand_ok = valid_ff[rd_idx_ff] && (rd_data.order_id == req_ff.order_id);
         better = !found_ff || (age_new < age_best);
      end else begin
         cand_ok = valid_ff[rd_idx_ff] && (rd_data.side != req_ff.order_side);
         if (!found_ff) begin
            better = 1'b1;
         end else if (rd_data.price != best_ff.price) begin
            better = (rd_data.side == SIDE_BUY) ? (rd_data.price > best_ff.price)
                                                : (rd_data.price < best_ff.price);
         end else begin
            better = age_new > age_best;
         end
      end
   end

   logic scan_done;
   assign scan_done = (scan_ff == CNT_W'(ORDER_SLOTS)) && !rd_pend_ff;

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      valid_in = valid_ff;
      arrival_in = arrival_ff;
      scan_in = scan_ff;
      rd_pend_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      found_in = found_ff;
      best_idx_in = best_idx_ff;
      best_in = best_ff;
      bid_in = bid_ff; ask_in = ask_ff;
      bidp_in = bidp_ff; askp_in = askp_ff;
      bida_in = bida_ff; aska_in = aska_ff;
      qty_in = qty_ff;
      status_in = status_ff;
      left_in = left_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en = 1'b0;
      wr_addr = best_idx_ff;
      wr_data = best_ff;
      rd_addr = scan_ff[SLOT_W-1:0];
      req.ready = 1'b0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               req_in = req.payload;
               qty_in = req.payload.order_quantity;
               status_in = ST_ACCEPTED;
               left_in = '0;
               scan_in = '0;
               found_in = 1'b0;
               if (req.payload.operation == OP_SUBMIT &&
                   req.payload.order_quantity == '0) begin
                  status_in = ST_REJECTED;
                  state_in = S_SUM;
                  bid_in = 1'b0; ask_in = 1'b0;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN, S_SUM: begin
            // issue one read per cycle, fold in the returned slot
            if (scan_ff != CNT_W'(ORDER_SLOTS)) begin
               rd_pend_in = 1'b1;
               rd_idx_in = scan_ff[SLOT_W-1:0];
               scan_in = scan_ff + CNT_W'(1);
            end
            if (rd_pend_ff && valid_ff[rd_idx_ff]) begin
               if (state_ff == S_SCAN) begin
                  if (cand_ok && better) begin
                     found_in = 1'b1;
                     best_idx_in = rd_idx_ff;
                     best_in = rd_data;
                  end
               end else if (rd_data.side == SIDE_BUY) begin
                  if (!bid_ff || rd_data.price > bidp_ff ||
                      (rd_data.price == bidp_ff && age_new > (arrival_ff - bida_ff))) begin
                     bid_in = 1'b1; bidp_in = rd_data.price; bida_in = rd_data.arrival;
                  end
               end else begin
                  if (!ask_ff || rd_data.price < askp_ff ||
                      (rd_data.price == askp_ff && age_new > (arrival_ff - aska_ff))) begin
                     ask_in = 1'b1; askp_in = rd_data.price; aska_in = rd_data.arrival;
                  end
               end
            end
            if (scan_done) begin
               if (state_ff == S_SCAN) begin
                  state_in = S_DECIDE;
               end else if (!rsp_valid_ff || rsp.ready) begin
                  rsp_in = '0;
                  rsp_in.result_kind = RES_SUMMARY;
                  rsp_in.taker_id = req_ff.order_id;
                  rsp_in.status = status_ff;
                  rsp_in.leftover_quantity = left_ff;
                  rsp_in.bid_present = bid_ff;
                  rsp_in.best_bid_price = bid_ff ? bidp_ff : '0;
                  rsp_in.ask_present = ask_ff;
                  rsp_in.best_ask_price = ask_ff ? askp_ff : '0;
                  rsp_in.last_result = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in = S_OUT;
               end
            end
         end
         S_DECIDE: begin
            scan_in = '0;
            if (req_ff.operation == OP_CANCEL) begin
               if (found_ff) begin
                  valid_in[best_idx_ff] = 1'b0;
                  status_in = ST_CANCELLED;
               end else begin
                  status_in = ST_NOT_FOUND;
               end
               bid_in = 1'b0; ask_in = 1'b0;
               state_in = S_SUM;
            end else if (found_ff && crosses) begin
               state_in = S_TRADE;
            end else begin
               // rest or drop remainder
               if (req_ff.order_kind == KIND_MARKET) begin
                  left_in = qty_ff;
               end else if (!free_any) begin
                  status_in = ST_BOOK_FULL;
                  left_in = qty_ff;
               end else begin
                  wr_en = 1'b1;
                  wr_addr = free_idx;
                  wr_data.side = req_ff.order_side;
                  wr_data.order_id = req_ff.order_id;
                  wr_data.price = req_ff.limit_price;
                  wr_data.quantity = qty_ff;
                  wr_data.arrival = arrival_ff;
                  valid_in[free_idx] = 1'b1;
                  arrival_in = arrival_ff + 32'd1;
               end
               bid_in = 1'b0; ask_in = 1'b0;
               state_in = S_SUM;
            end
         end
         S_TRADE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_in = '0;
               rsp_in.result_kind = RES_TRADE;
               rsp_in.maker_id = best_ff.order_id;
               rsp_in.taker_id = req_ff.order_id;
               rsp_in.trade_price = best_ff.price;
               rsp_in.fill_quantity = fill;
               rsp_valid_in = 1'b1;
               wr_en = 1'b1;
               wr_data.quantity = best_ff.quantity - fill;
               if (best_ff.quantity == fill) begin
                  valid_in[best_idx_ff] = 1'b0;
               end
               qty_in = qty_ff - fill;
               found_in = 1'b0;
               scan_in = '0;
               if (qty_ff == fill) begin
                  bid_in = 1'b0; ask_in = 1'b0;
                  state_in = S_SUM;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         arrival_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         scan_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         arrival_ff <= arrival_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff <= rd_pend_in;
         scan_ff <= scan_in;
      end
      req_ff <= req_in;
      rd_idx_ff <= rd_idx_in;
      found_ff <= found_in;
      best_idx_ff <= best_idx_in;
      best_ff <= best_in;
      bid_ff <= bid_in; ask_ff <= ask_in;
      bidp_ff <= bidp_in; askp_ff <= askp_in;
      bida_ff <= bida_in; aska_ff <= aska_in;
      qty_ff <= qty_in;
      status_ff <= status_in;
      left_ff <= left_in;
      rsp_ff <= rsp_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   logic zero_fill, last_ok, trade_go;
   assign zero_fill = rsp.valid && rsp.payload.result_kind == RES_TRADE &&
                      rsp.payload.fill_quantity == '0;
   assign last_ok = rsp.payload.last_result == rsp.payload.result_kind;
   assign trade_go = state_ff == S_TRADE && (!rsp_valid_ff || rsp.ready);

   `ASSERT_CLK(a_ready_idle, clock, reset, !req.ready || state_ff == S_IDLE, "ready outside idle")
   `ASSERT_CLK(a_fill_nonzero, clock, reset, !zero_fill, "zero fill")
   `ASSERT_CLK(a_last_summary, clock, reset, !rsp.valid || last_ok, "last flag mismatch")
   `ASSERT_NEXT(a_trade_to_rsp, clock, reset, trade_go, rsp_valid_ff, "trade not presented")
endmodule
`default_nettype wire
